/* rtl/core/mih_pkg.sv */
// Shared types and constants for the masked intensity histogram.
package mih_pkg;

    // Field widths of the word formats.
    localparam int COUNT_BITS    = 22;
    localparam int FRACTION_BITS = 16;
    localparam int BIN_BITS      = 8;
    localparam int NUM_BINS      = 256;

    localparam logic [7:0]            MASK_INSIDE = 8'd255;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

    // Input mode codes.
    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pixel;
        logic [7:0] mask_byte;
        logic [7:0] bin_index;
    } t_in_word;

    typedef struct packed {
        logic [7:0]               bin_number;
        logic [COUNT_BITS-1:0]    bin_count;
        logic [COUNT_BITS-1:0]    total_count;
        logic [FRACTION_BITS:0]   bin_fraction;
        logic                     empty_flag;
    } t_out_word;

    // Commands handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_READ,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [BIN_BITS-1:0]  bin;
    } t_cmd;

    // Read request handed from the back end to the divider.
    typedef struct packed {
        logic [BIN_BITS-1:0]   bin;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] total;
    } t_div_req;

endpackage

/* rtl/core/mih_ram.sv */
// Generic single-write, single-read RAM with registered read-first output.
module mih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; a read sees the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/mih_front.sv */
// Front end: holds the mask enable and turns input words into commands.
module mih_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    input  mih_pkg::t_in_word i_in_word,
    output logic              o_in_stall,
    input  logic              i_q_full,
    output logic              o_q_push,
    output mih_pkg::t_cmd     o_q_cmd
);

    logic r_mask_en;
    logic accept;
    logic keep;

    // Mask enable register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_en <= 1'b0;
        end else if (i_cfg_wr) begin
            r_mask_en <= i_cfg_data;
        end
    end

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // Classify the word; unused modes and masked-out pixels are dropped here.
    always_comb begin
        keep          = 1'b0;
        o_q_cmd.kind  = mih_pkg::CMD_PIXEL;
        o_q_cmd.bin   = i_in_word.pixel;
        case (i_in_word.mode)
            mih_pkg::MODE_PIXEL: begin
                keep = !r_mask_en || (i_in_word.mask_byte == mih_pkg::MASK_INSIDE);
            end
            mih_pkg::MODE_READ: begin
                keep         = 1'b1;
                o_q_cmd.kind = mih_pkg::CMD_READ;
                o_q_cmd.bin  = i_in_word.bin_index;
            end
            mih_pkg::MODE_CLEAR: begin
                keep         = 1'b1;
                o_q_cmd.kind = mih_pkg::CMD_CLEAR;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_q_push = accept && keep;

endmodule

/* rtl/core/mih_fifo.sv */
// Short command queue between the front end and the back end.
module mih_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mih_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mih_pkg::t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mih_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

/* rtl/core/mih_back.sv */
// Back end: bin memory, read-modify-write pipeline, total and clear logic.
module mih_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  mih_pkg::t_cmd     i_q_head,
    output logic              o_q_pop,
    output logic              o_div_start,
    output mih_pkg::t_div_req o_div_req,
    input  logic              i_div_ready
);

    localparam int CB = mih_pkg::COUNT_BITS;

    // Execute stage, in the cycle after the memory read was issued.
    logic                           r_b_valid;
    mih_pkg::t_cmd                  r_b;
    logic [mih_pkg::NUM_BINS-1:0]   r_bin_valid;
    logic [CB-1:0]                  r_total;
    logic                           r_fwd_valid;
    logic [mih_pkg::BIN_BITS-1:0]   r_fwd_bin;
    logic [CB-1:0]                  r_fwd_count;

    logic [CB-1:0] ram_rd_data;
    logic          b_advance;
    logic          is_pixel;
    logic          is_read;
    logic          is_clear;
    logic          fwd_hit;
    logic [CB-1:0] cur_count;
    logic [CB-1:0] n_count;
    logic [CB-1:0] n_total;

    assign is_pixel = r_b_valid && (r_b.kind == mih_pkg::CMD_PIXEL);
    assign is_read  = r_b_valid && (r_b.kind == mih_pkg::CMD_READ);
    assign is_clear = r_b_valid && (r_b.kind == mih_pkg::CMD_CLEAR);

    // A read holds the stage until the divider takes it.
    assign b_advance   = !is_read || i_div_ready;
    assign o_q_pop     = i_q_valid && b_advance;
    assign o_div_start = is_read && i_div_ready;

    mih_ram #(
        .WIDTH(CB),
        .DEPTH(mih_pkg::NUM_BINS)
    ) u_bins (
        .i_clk     (i_clk),
        .i_wr_en   (is_pixel),
        .i_wr_addr (r_b.bin),
        .i_wr_data (n_count),
        .i_rd_en   (o_q_pop),
        .i_rd_addr (i_q_head.bin),
        .o_rd_data (ram_rd_data)
    );

    // Current bin value: latest write wins, a bin not written since clear is zero.
    assign fwd_hit   = r_fwd_valid && (r_fwd_bin == r_b.bin);
    assign cur_count = fwd_hit ? r_fwd_count :
                       (r_bin_valid[r_b.bin] ? ram_rd_data : '0);
    assign n_count   = (cur_count == mih_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;
    assign n_total   = (r_total == mih_pkg::COUNT_MAX) ? r_total : r_total + 1'b1;

    assign o_div_req.bin   = r_b.bin;
    assign o_div_req.count = cur_count;
    assign o_div_req.total = r_total;

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_advance) begin
            r_b_valid <= o_q_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b <= i_q_head;
        end
    end

    // Valid flags, total and forwarding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || is_clear) begin
            r_bin_valid <= '0;
            r_total     <= '0;
            r_fwd_valid <= 1'b0;
        end else if (is_pixel) begin
            r_bin_valid[r_b.bin] <= 1'b1;
            r_total              <= n_total;
            r_fwd_valid          <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_pixel) begin
            r_fwd_bin   <= r_b.bin;
            r_fwd_count <= n_count;
        end
    end

    // A clear leaves every bin and the total empty.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_clear |=> (r_total == '0) && (r_bin_valid == '0) && !r_fwd_valid)
        else $error("clear did not empty the histogram");

    // No bin can overtake the total.
    a_bin_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_pixel |-> (n_count <= n_total))
        else $error("bin count exceeds total");

endmodule

/* rtl/core/mih_divider.sv */
// Bit-serial fraction divider that also holds the result word for the receiver.
module mih_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mih_pkg::t_div_req  i_req,
    output logic               o_ready,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mih_pkg::t_out_word o_out_word
);

    localparam int CB     = mih_pkg::COUNT_BITS;
    localparam int FB     = mih_pkg::FRACTION_BITS;
    localparam int STEP_W = $clog2(FB);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state                       r_state;
    logic [mih_pkg::BIN_BITS-1:0] r_bin;
    logic [CB-1:0]                r_count;
    logic [CB-1:0]                r_total;
    logic [CB-1:0]                r_rem;
    logic [FB:0]                  r_quo;
    logic [STEP_W-1:0]            r_step;

    logic [CB:0] rem2;
    logic        ge;
    logic        q0;

    // One quotient bit per cycle from the shifted remainder.
    assign rem2 = {r_rem, 1'b0};
    assign ge   = (rem2 >= {1'b0, r_total});
    assign q0   = (i_req.count >= i_req.total);

    // Control state and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_bin   <= i_req.bin;
                        r_count <= i_req.count;
                        r_total <= i_req.total;
                        r_step  <= '0;
                        if (i_req.total == '0) begin
                            r_quo   <= '0;
                            r_rem   <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_quo   <= (FB + 1)'(q0);
                            r_rem   <= q0 ? i_req.count - i_req.total : i_req.count;
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    r_rem  <= ge ? CB'(rem2 - {1'b0, r_total}) : CB'(rem2);
                    r_quo  <= {r_quo[FB-1:0], ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(FB - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_DONE);

    assign o_out_word.bin_number   = r_bin;
    assign o_out_word.bin_count    = r_count;
    assign o_out_word.total_count  = r_total;
    assign o_out_word.bin_fraction = r_quo;
    assign o_out_word.empty_flag   = (r_total == '0);

    // The partial remainder always stays below the divisor.
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_rem < r_total))
        else $error("partial remainder out of range");

    // A finished fraction never exceeds one.
    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (r_quo <= {1'b1, {FB{1'b0}}}))
        else $error("fraction above one");

endmodule

/* rtl/core/masked_intensity_histogram_core.sv */
// Top level of the masked intensity histogram core.
//
// Input channel (i_in_valid / o_in_stall, word i_in_word): mode 0 counts a
// pixel in its bin and in the total, gated by the mask when masking is on;
// mode 1 reads one bin; mode 2 clears all bins and the total; mode 3 is
// dropped. Only reads produce a word on the output channel
// (o_out_valid / i_out_stall, word o_out_word).
// The configuration channel (i_cfg_valid / o_cfg_ready) writes mask_enable
// and is always ready.
// Throughput: one pixel or clear word per cycle while no read holds the back
// end. A read passes through the queue, the execute stage and the
// bit-serial divider, which produces one fraction bit per cycle; the
// divider takes no new read until the receiver has taken the last result.
// The result is held in the divider's output register until the receiver
// takes it. Words behind a read queue up (QUEUE_DEPTH entries) and the
// back end holds while the divider is busy or a result waits, after which
// o_in_stall rises once the queue is full.
// Reset empties the queue, disables masking and marks every bin empty at
// once through per-bin valid flags, so words are taken from the first cycle.
module masked_intensity_histogram_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mih_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mih_pkg::t_out_word o_out_word
);

    logic              q_full;
    logic              q_push;
    mih_pkg::t_cmd     q_push_cmd;
    logic              q_pop;
    logic              q_valid;
    mih_pkg::t_cmd     q_head;
    logic              div_start;
    logic              div_ready;
    mih_pkg::t_div_req div_req;

    assign o_cfg_ready = 1'b1;

    mih_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_push_cmd)
    );

    mih_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    mih_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_div_start (div_start),
        .o_div_req   (div_req),
        .i_div_ready (div_ready)
    );

    mih_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_req       (div_req),
        .o_ready     (div_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

/* dv/tb_masked_intensity_histogram_core.sv */
// Self-checking testbench for the masked intensity histogram core.
`timescale 1ns / 1ps

module tb_masked_intensity_histogram_core;

    // Mode 3 has no name in the package; the core drops such words.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Cycles allowed for queued pixel words to drain behind the last read.
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 160;

    // One line of the directed stimulus: a mask write or an input word,
    // optionally with the read result typed in by hand.
    typedef struct packed {
        logic               is_cfg;
        logic               cfg_value;
        mih_pkg::t_in_word  word;
        logic               typed;
        mih_pkg::t_out_word typed_out;
    } t_stim_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    mih_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    mih_pkg::t_out_word out_word;

    // Predicted histogram state.
    logic [mih_pkg::COUNT_BITS-1:0] bin_tally [0:mih_pkg::NUM_BINS-1];
    logic [mih_pkg::COUNT_BITS-1:0] pixels_counted;
    logic                           mask_on;

    mih_pkg::t_out_word expected_reads [$];
    int        mismatches = 0;
    int        burst_left = 0;
    int        gap_len = 0;
    bit        stream_fresh = 1'b1;
    int        stall_density = 0;
    int        stall_stretch = 0;

    masked_intensity_histogram_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Updates the predicted histogram with one accepted word and works out
    // the read result, if the word is a read.
    task automatic track_histogram(input mih_pkg::t_in_word w, output bit has_out,
                                   output mih_pkg::t_out_word o);
        logic [63:0] scaled;
        logic [63:0] quotient;
        has_out = 1'b0;
        o = '0;
        case (w.mode)
            mih_pkg::MODE_PIXEL: begin
                if (!mask_on || w.mask_byte == mih_pkg::MASK_INSIDE) begin
                    if (bin_tally[w.pixel] != mih_pkg::COUNT_MAX)
                        bin_tally[w.pixel] = bin_tally[w.pixel] + 1'b1;
                    if (pixels_counted != mih_pkg::COUNT_MAX)
                        pixels_counted = pixels_counted + 1'b1;
                end
            end
            mih_pkg::MODE_READ: begin
                has_out = 1'b1;
                o.bin_number = w.bin_index;
                o.bin_count = bin_tally[w.bin_index];
                o.total_count = pixels_counted;
                if (pixels_counted == '0) begin
                    o.empty_flag = 1'b1;
                end else begin
                    // Share of the total, truncated, with 16 fraction bits.
                    scaled = 64'(bin_tally[w.bin_index]);
                    scaled = scaled << mih_pkg::FRACTION_BITS;
                    quotient = scaled / 64'(pixels_counted);
                    o.bin_fraction = quotient[mih_pkg::FRACTION_BITS:0];
                end
            end
            mih_pkg::MODE_CLEAR: begin
                for (int b = 0; b < mih_pkg::NUM_BINS; b++)
                    bin_tally[b] = '0;
                pixels_counted = '0;
            end
            default: ;
        endcase
    endtask

    // Compares one read result with its expectation, field by field.
    task automatic check_read(input mih_pkg::t_out_word exp_w,
                              input mih_pkg::t_out_word got);
        if (got.bin_number !== exp_w.bin_number) begin
            mismatches++;
            $display("%0t bin_number: expected %0d, got %0d", $time,
                     exp_w.bin_number, got.bin_number);
        end
        if (got.bin_count !== exp_w.bin_count) begin
            mismatches++;
            $display("%0t bin_count (bin %0d): expected %0d, got %0d", $time,
                     exp_w.bin_number, exp_w.bin_count, got.bin_count);
        end
        if (got.total_count !== exp_w.total_count) begin
            mismatches++;
            $display("%0t total_count: expected %0d, got %0d", $time,
                     exp_w.total_count, got.total_count);
        end
        if (got.bin_fraction !== exp_w.bin_fraction) begin
            mismatches++;
            $display("%0t bin_fraction (bin %0d): expected %0d, got %0d", $time,
                     exp_w.bin_number, exp_w.bin_fraction, got.bin_fraction);
        end
        if (got.empty_flag !== exp_w.empty_flag) begin
            mismatches++;
            $display("%0t empty_flag: expected %0b, got %0b", $time,
                     exp_w.empty_flag, got.empty_flag);
        end
    endtask

    // Offers one word at a falling edge and holds it until it is taken.
    task automatic send_word(input mih_pkg::t_in_word w, input bit typed,
                             input mih_pkg::t_out_word typed_out);
        bit                 has_out;
        mih_pkg::t_out_word predicted;
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        track_histogram(w, has_out, predicted);
        if (has_out)
            expected_reads.push_back(typed ? typed_out : predicted);
        @(negedge clk);
    endtask

    // Bursts of back-to-back words separated by random gaps.
    task automatic sender_pause();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            gap_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 4);
            if (gap_len != 0) begin
                in_valid <= 1'b0;
                repeat (gap_len) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic stream_word(input mih_pkg::t_in_word w, input bit typed,
                               input mih_pkg::t_out_word typed_out);
        if (!stream_fresh)
            sender_pause();
        stream_fresh = 1'b0;
        send_word(w, typed, typed_out);
    endtask

    // Waits until every read has returned and queued pixels have drained.
    task automatic wait_idle();
        in_valid <= 1'b0;
        stream_fresh = 1'b1;
        while (expected_reads.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mask(input logic value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        mask_on = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_stim_row row(input logic is_cfg, input logic cfg_value,
                                      input mih_pkg::t_in_word w, input logic typed,
                                      input mih_pkg::t_out_word o);
        t_stim_row r;
        r.is_cfg = is_cfg;
        r.cfg_value = cfg_value;
        r.word = w;
        r.typed = typed;
        r.typed_out = o;
        return r;
    endfunction

    // The receiver stalls in stretches of differing density, none included.
    always @(negedge clk) begin
        if (stall_stretch == 0) begin
            case ($urandom_range(0, 3))
                0: stall_density = 0;
                1: stall_density = 25;
                2: stall_density = 60;
                default: stall_density = 90;
            endcase
            stall_stretch = $urandom_range(20, 300);
        end
        stall_stretch--;
        out_stall <= ($urandom_range(0, 99) < stall_density);
    end

    // Every taken result is matched against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_reads.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result: expected none, got bin %0d count %0d",
                         $time, out_word.bin_number, out_word.bin_count);
            end else begin
                check_read(expected_reads.pop_front(), out_word);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_stim_row         directed [$];
        mih_pkg::t_in_word w;
        logic [7:0]        hot [0:3];
        int                pick;

        for (int b = 0; b < mih_pkg::NUM_BINS; b++)
            bin_tally[b] = '0;
        pixels_counted = '0;
        mask_on = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty histogram, ignored mode, full and zero shares,
        // clearing, alternating bit patterns, then masking.
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd0, 8'd0, 8'd0},
                               1'b1, {8'd0, 22'd0, 22'd0, 17'd0, 1'b1}));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd0, 8'd0, 8'd255},
                               1'b1, {8'd255, 22'd0, 22'd0, 17'd0, 1'b1}));
        directed.push_back(row(1'b0, 1'b0, {MODE_UNUSED, 8'd255, 8'd255, 8'd255},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd0, 8'd0, 8'd255},
                               1'b1, {8'd255, 22'd0, 22'd0, 17'd0, 1'b1}));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_PIXEL, 8'd0, 8'd0, 8'd0},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd0, 8'd0, 8'd0},
                               1'b1, {8'd0, 22'd1, 22'd1, 17'd65536, 1'b0}));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_PIXEL, 8'd255, 8'd255, 8'd0},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_PIXEL, 8'd255, 8'd0, 8'd255},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd255, 8'd255, 8'd255},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd0, 8'd0, 8'd1},
                               1'b1, {8'd1, 22'd0, 22'd3, 17'd0, 1'b0}));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_CLEAR, 8'hAA, 8'h55, 8'h0F},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd0, 8'd0, 8'd0},
                               1'b1, {8'd0, 22'd0, 22'd0, 17'd0, 1'b1}));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_PIXEL, 8'd170, 8'd85, 8'd0},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_PIXEL, 8'd85, 8'd170, 8'd0},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_PIXEL, 8'd85, 8'd1, 8'd0},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd0, 8'd0, 8'd85},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd0, 8'd0, 8'd170},
                               1'b0, '0));
        directed.push_back(row(1'b1, 1'b1, '0, 1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_CLEAR, 8'h55, 8'hAA, 8'hF0},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_PIXEL, 8'd7, 8'd254, 8'd0},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_PIXEL, 8'd7, 8'd255, 8'd0},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_PIXEL, 8'd7, 8'd0, 8'd0},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd0, 8'd0, 8'd7},
                               1'b1, {8'd7, 22'd1, 22'd1, 17'd65536, 1'b0}));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_PIXEL, 8'd8, 8'd255, 8'd0},
                               1'b0, '0));
        directed.push_back(row(1'b0, 1'b0, {mih_pkg::MODE_READ, 8'd0, 8'd0, 8'd7},
                               1'b0, '0));

        foreach (directed[i]) begin
            if (directed[i].is_cfg)
                write_mask(directed[i].cfg_value);
            else
                stream_word(directed[i].word, directed[i].typed, directed[i].typed_out);
        end

        // Random part: each phase runs under its own mask setting and piles
        // most pixels onto a few hot bins so that shares span a wide range.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_mask(1'(phase % 2));
            for (int k = 0; k < 4; k++)
                hot[k] = 8'($urandom_range(0, 255));
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                w.pixel = 8'($urandom_range(0, 255));
                w.mask_byte = ($urandom_range(0, 9) < 6) ? mih_pkg::MASK_INSIDE
                                                         : 8'($urandom_range(0, 255));
                w.bin_index = 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    w.mode = mih_pkg::MODE_CLEAR;
                end else if (pick < 5) begin
                    w.mode = MODE_UNUSED;
                end else if (pick < 20) begin
                    w.mode = mih_pkg::MODE_READ;
                    if ($urandom_range(0, 4) != 0)
                        w.bin_index = hot[2'($urandom_range(0, 3))];
                end else begin
                    w.mode = mih_pkg::MODE_PIXEL;
                    if ($urandom_range(0, 3) != 0)
                        w.pixel = hot[2'($urandom_range(0, 3))];
                end
                stream_word(w, 1'b0, '0);
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
